// ===== hdl/sqlss_pkg.sv =====
// Package for the SQL statement splitter: scanner state codes, action bits,
// character constants and the result word layout. No dependencies.
package sqlss_pkg;

    typedef enum logic [15:0] {
        ST_WHTE = 16'h0001,   // leading whitespace
        ST_BODY = 16'h0002,
        ST_LCOM = 16'h0004,   // inside a line comment
        ST_LCO1 = 16'h0008,   // one dash held
        ST_LCO2 = 16'h0010,   // two dashes held
        ST_CCOM = 16'h0020,
        ST_CCO1 = 16'h0040,
        ST_CCO2 = 16'h0080,
        ST_SSTR = 16'h0100,
        ST_SST1 = 16'h0200,
        ST_DSTR = 16'h0400,
        ST_DST1 = 16'h0800,
        ST_BQTS = 16'h1000,   // escape inside single-quoted string
        ST_BQTD = 16'h2000,   // escape inside double-quoted string
        ST_LIT  = 16'h4000,   // back-quoted name
        ST_TERM = 16'h8000    // statement end, never stored
    } t_scan_state;

    typedef struct packed {
        logic copy;
        logic hold;
        logic xfer;
        logic drop;
    } t_action;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       stmt_end;
        logic       last;
    } t_result;

    localparam int RES_DEPTH = 3;

    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_DASH   = 8'h2D;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_BTICK  = 8'h60;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_BSLASH = 8'h5C;

endpackage

// ===== hdl/sqlss_if.sv =====
// Valid/ready channel interfaces for the SQL statement splitter.
// Input channel carries one script byte, output channel one result word.
interface sqlss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_script;

    modport source (output valid, output in_byte, output end_of_script, input ready);
    modport sink   (input valid, input in_byte, input end_of_script, output ready);
endinterface

interface sqlss_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       stmt_end;
    logic       last;

    modport source (output valid, output char_valid, output out_char, output stmt_end,
                    output last, input ready);
    modport sink   (input valid, input char_valid, input out_char, input stmt_end,
                    input last, output ready);
endinterface

// ===== hdl/sql_statement_splitter.sv =====
// SQL statement splitter top level: input register, scanner, result buffer.
// Depends on sqlss_pkg and the channel interfaces in sqlss_if.sv.
//
//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+-----------
//  i_in    | in  | in_byte[7:0], end_of_script            | valid/ready
//  o_out   | out | char_valid, out_char[7:0], stmt_end,   | valid/ready
//          |     | last                                   |
//
// Flow: a byte waits in the input register, then the scanner writes its 1 to 3
// result words into the result buffer. A byte that makes one word flows at one
// byte per cycle while the output takes each word; after a byte that releases
// held dashes, the next byte waits until the single output port drains the buffer.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// scanner to leading whitespace with nothing held.
// Stalls: the input register keeps taking bytes while the last buffered word
// waits, as long as that word leaves in the same cycle the next one loads.
module sql_statement_splitter
    import sqlss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sqlss_in_if.sink           i_in,
    sqlss_out_if.source        o_out
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;

    // scanner state
    t_scan_state r_state;
    logic [7:0]  r_held [2];
    logic [1:0]  r_held_cnt;

    // result buffer, head at entry 0
    t_result     r_res [RES_DEPTH];
    logic [1:0]  r_res_cnt;

    t_scan_state n_state;
    t_action     act;
    logic        is_ws;
    logic        fin;
    logic [1:0]  xfer_cnt;
    logic [1:0]  emit_cnt;
    logic [7:0]  emit [RES_DEPTH];
    t_result     n_res [RES_DEPTH];
    logic [1:0]  n_res_cnt;
    logic        pop;
    logic        load_ok;
    logic        proc;

    assign pop     = o_out.valid && o_out.ready;
    assign load_ok = (r_res_cnt == 2'd0) || ((r_res_cnt == 2'd1) && pop);
    assign proc    = r_in_valid && load_ok;

    assign i_in.ready       = !r_in_valid || load_ok;
    assign o_out.valid      = (r_res_cnt != 2'd0);
    assign o_out.char_valid = r_res[0].char_valid;
    assign o_out.out_char   = r_res[0].out_char;
    assign o_out.stmt_end   = r_res[0].stmt_end;
    assign o_out.last       = r_res[0].last;

    assign is_ws = (r_in_byte == C_SPACE) || (r_in_byte == C_TAB) || (r_in_byte == C_LF)
                || (r_in_byte == C_CR) || (r_in_byte == C_FF);

    // Scanner transition. Unlisted pairs stay put and copy the byte.
    always_comb begin
        act     = '{copy: 1'b1, hold: 1'b0, xfer: 1'b0, drop: 1'b0};
        n_state = r_state;
        unique case (r_state)
            ST_BODY: begin
                if (r_in_byte == C_HASH) begin
                    act.copy = 1'b0;
                    n_state  = ST_LCOM;
                end else if (r_in_byte == C_SQUOTE) begin
                    n_state = ST_SSTR;
                end else if (r_in_byte == C_DASH) begin
                    act.copy = 1'b0;
                    act.hold = 1'b1;
                    n_state  = ST_LCO1;
                end else if (r_in_byte == C_SLASH) begin
                    n_state = ST_CCO1;
                end else if (r_in_byte == C_DQUOTE) begin
                    n_state = ST_DSTR;
                end else if (r_in_byte == C_BTICK) begin
                    n_state = ST_LIT;
                end else if (r_in_byte == C_SEMI) begin
                    act.copy = 1'b0;
                    n_state  = ST_TERM;
                end
            end
            ST_BQTD: n_state = ST_DSTR;
            ST_BQTS: n_state = ST_SSTR;
            ST_CCO1: n_state = (r_in_byte == C_STAR)  ? ST_CCOM : ST_BODY;
            ST_CCO2: n_state = (r_in_byte == C_SLASH) ? ST_BODY : ST_CCOM;
            ST_CCOM: n_state = (r_in_byte == C_STAR)  ? ST_CCO2 : ST_CCOM;
            ST_DST1: begin
                if (r_in_byte == C_DQUOTE)    n_state = ST_DSTR;
                else if (r_in_byte == C_SEMI) n_state = ST_TERM;
                else                          n_state = ST_BODY;
            end
            ST_DSTR: begin
                if (r_in_byte == C_DQUOTE)      n_state = ST_DST1;
                else if (r_in_byte == C_BSLASH) n_state = ST_BQTD;
            end
            ST_LCO1, ST_LCO2: begin
                if ((r_state == ST_LCO1) && (r_in_byte == C_DASH)) begin
                    act.copy = 1'b0;
                    act.hold = 1'b1;
                    n_state  = ST_LCO2;
                end else if ((r_state == ST_LCO2)
                             && ((r_in_byte == C_SPACE) || (r_in_byte == C_TAB))) begin
                    // "-- " or "--<tab>" opens a line comment: held dashes vanish
                    act.copy = 1'b0;
                    act.drop = 1'b1;
                    n_state  = ST_LCOM;
                end else begin
                    act.xfer = 1'b1;
                    if (r_in_byte == C_SQUOTE)      n_state = ST_SSTR;
                    else if (r_in_byte == C_DQUOTE) n_state = ST_DSTR;
                    else                            n_state = ST_BODY;
                end
            end
            ST_LCOM: begin
                act.copy = 1'b0;
                n_state  = (r_in_byte == C_LF) ? ST_BODY : ST_LCOM;
            end
            ST_SST1: begin
                if (r_in_byte == C_SQUOTE)    n_state = ST_SSTR;
                else if (r_in_byte == C_SEMI) n_state = ST_TERM;
                else                          n_state = ST_BODY;
            end
            ST_SSTR: begin
                if (r_in_byte == C_SQUOTE)      n_state = ST_SST1;
                else if (r_in_byte == C_BSLASH) n_state = ST_BQTS;
            end
            ST_LIT: n_state = (r_in_byte == C_BTICK) ? ST_BODY : ST_LIT;
            default: begin
                // leading whitespace, and any stray code
                if (is_ws) begin
                    act.copy = 1'b0;
                    n_state  = ST_WHTE;
                end else begin
                    n_state = ST_BODY;
                end
            end
        endcase
    end

    assign fin      = (n_state == ST_TERM) || r_in_eos;
    assign xfer_cnt = act.xfer ? r_held_cnt : 2'd0;
    assign emit_cnt = xfer_cnt + {1'b0, act.copy};

    // released dashes first, then the copied byte
    assign emit[0] = (xfer_cnt >= 2'd1) ? r_held[0] : r_in_byte;
    assign emit[1] = (xfer_cnt >= 2'd2) ? r_held[1] : r_in_byte;
    assign emit[2] = r_in_byte;

    always_comb begin
        for (int k = 0; k < RES_DEPTH; k++) begin
            n_res[k].char_valid = 1'b1;
            n_res[k].out_char   = emit[k];
            n_res[k].last       = (2'(k) == emit_cnt - 2'd1);
            n_res[k].stmt_end   = (2'(k) == emit_cnt - 2'd1) && fin;
        end
        n_res_cnt = emit_cnt;
        if (emit_cnt == 2'd0) begin
            // nothing emitted: one empty word
            n_res[0]  = '{char_valid: 1'b0, out_char: 8'h00, stmt_end: fin, last: 1'b1};
            n_res_cnt = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_WHTE;
            r_held_cnt <= 2'd0;
            r_res_cnt  <= 2'd0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc) begin
                r_state   <= fin ? ST_WHTE : n_state;
                r_res_cnt <= n_res_cnt;
                if (fin || act.xfer || act.drop) begin
                    r_held_cnt <= 2'd0;
                end else if (act.hold && (r_held_cnt < 2'd2)) begin
                    r_held_cnt <= r_held_cnt + 2'd1;
                end
            end else if (pop) begin
                r_res_cnt <= r_res_cnt - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_eos  <= i_in.end_of_script;
        end
        if (proc && act.hold && (r_held_cnt < 2'd2)) begin
            r_held[r_held_cnt[0]] <= r_in_byte;
        end
        if (proc) begin
            for (int k = 0; k < RES_DEPTH; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (pop) begin
            for (int k = 0; k < RES_DEPTH - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

endmodule

// ===== tb/sql_statement_splitter_test.sv =====
// Self-checking bench for sql_statement_splitter: directed table, then weighted
// random script bytes, every result word checked against a typed word or scanner model.
// Depends on sqlss_pkg and the channel interfaces in sqlss_if.sv.
module sql_statement_splitter_test
    import sqlss_pkg::*;
();

    logic i_clk = 1'b0;
    logic i_rst_n;

    sqlss_in_if  in_ch ();
    sqlss_out_if out_ch ();

    sql_statement_splitter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Directed stimulus row: byte, end flag, and an optional hand-written result.
    // Rows without one are checked against the scanner model below.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       eos;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam t_result NO_WANT     = '0;
    localparam t_result W_EMPTY     = '{1'b0, 8'h00, 1'b0, 1'b1};
    localparam t_result W_EMPTY_END = '{1'b0, 8'h00, 1'b1, 1'b1};
    localparam t_result W_SEMI_END  = '{1'b1, C_SEMI, 1'b1, 1'b1};

    localparam int N_DIR = 29;
    localparam int N_RAND = 400;

    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{C_SPACE,  1'b0, 1'b1, W_EMPTY},                      // whitespace skipped
        '{8'h00,    1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1}},   // zero byte starts stmt
        '{8'hFF,    1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b1}},
        '{C_DASH,   1'b0, 1'b1, W_EMPTY},                      // dash held back
        '{C_SEMI,   1'b0, 1'b0, NO_WANT},                      // releases dash, no end
        '{C_DASH,   1'b0, 1'b0, NO_WANT},
        '{C_DASH,   1'b0, 1'b0, NO_WANT},
        '{C_TAB,    1'b0, 1'b0, NO_WANT},                      // "--<tab>" comment
        '{C_LF,     1'b0, 1'b0, NO_WANT},
        '{C_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{C_BSLASH, 1'b0, 1'b0, NO_WANT},
        '{C_SQUOTE, 1'b0, 1'b0, NO_WANT},                      // escaped quote
        '{C_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{C_SEMI,   1'b0, 1'b1, W_SEMI_END},                   // ';' after closing quote
        '{C_HASH,   1'b0, 1'b0, NO_WANT},                      // '#' as first char copied
        '{C_SLASH,  1'b0, 1'b0, NO_WANT},
        '{C_STAR,   1'b0, 1'b0, NO_WANT},
        '{C_STAR,   1'b0, 1'b0, NO_WANT},
        '{C_SLASH,  1'b0, 1'b0, NO_WANT},
        '{C_BTICK,  1'b0, 1'b0, NO_WANT},
        '{C_SEMI,   1'b0, 1'b0, NO_WANT},                      // ';' inside name
        '{C_BTICK,  1'b0, 1'b0, NO_WANT},
        '{C_DASH,   1'b0, 1'b0, NO_WANT},
        '{C_DASH,   1'b0, 1'b0, NO_WANT},
        '{C_DQUOTE, 1'b0, 1'b0, NO_WANT},                      // two dashes + quote out
        '{C_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{C_SEMI,   1'b0, 1'b1, W_SEMI_END},
        '{C_DASH,   1'b0, 1'b1, '{1'b1, C_DASH, 1'b0, 1'b1}}, // dash as first char
        '{C_DASH,   1'b1, 1'b1, W_EMPTY_END}                   // held dash dropped at end
    };

    // ---- scanner model ----
    t_scan_state scan;
    logic [7:0]  held [2];
    int          held_n;

    function automatic t_scan_state next_scan(input t_scan_state st, input logic [7:0] c,
                                              output t_action act);
        t_scan_state nxt;
        act = '0;
        act.copy = 1'b1;
        nxt = st;
        case (st)
            ST_BODY: begin
                case (c)
                    C_HASH:   begin act.copy = 1'b0; nxt = ST_LCOM; end
                    C_SQUOTE: nxt = ST_SSTR;
                    C_DASH:   begin act.copy = 1'b0; act.hold = 1'b1; nxt = ST_LCO1; end
                    C_SLASH:  nxt = ST_CCO1;
                    C_DQUOTE: nxt = ST_DSTR;
                    C_BTICK:  nxt = ST_LIT;
                    C_SEMI:   begin act.copy = 1'b0; nxt = ST_TERM; end
                    default:  nxt = ST_BODY;
                endcase
            end
            ST_BQTD: nxt = ST_DSTR;
            ST_BQTS: nxt = ST_SSTR;
            ST_CCO1: nxt = (c == C_STAR) ? ST_CCOM : ST_BODY;
            ST_CCO2: nxt = (c == C_SLASH) ? ST_BODY : ST_CCOM;
            ST_CCOM: nxt = (c == C_STAR) ? ST_CCO2 : ST_CCOM;
            ST_DST1: nxt = (c == C_DQUOTE) ? ST_DSTR : (c == C_SEMI) ? ST_TERM : ST_BODY;
            ST_DSTR: nxt = (c == C_DQUOTE) ? ST_DST1 : (c == C_BSLASH) ? ST_BQTD : ST_DSTR;
            ST_SST1: nxt = (c == C_SQUOTE) ? ST_SSTR : (c == C_SEMI) ? ST_TERM : ST_BODY;
            ST_SSTR: nxt = (c == C_SQUOTE) ? ST_SST1 : (c == C_BSLASH) ? ST_BQTS : ST_SSTR;
            ST_LIT:  nxt = (c == C_BTICK) ? ST_BODY : ST_LIT;
            ST_LCOM: begin
                act.copy = 1'b0;
                nxt = (c == C_LF) ? ST_BODY : ST_LCOM;
            end
            ST_LCO1, ST_LCO2: begin
                if (c == C_DASH && st == ST_LCO1) begin
                    act.copy = 1'b0;
                    act.hold = 1'b1;
                    nxt = ST_LCO2;
                end else if ((c == C_SPACE || c == C_TAB) && st == ST_LCO2) begin
                    act.copy = 1'b0;
                    act.drop = 1'b1;
                    nxt = ST_LCOM;
                end else begin
                    // not a comment after all: held dashes go out first
                    act.xfer = 1'b1;
                    nxt = (c == C_SQUOTE) ? ST_SSTR : (c == C_DQUOTE) ? ST_DSTR : ST_BODY;
                end
            end
            default: begin
                // leading whitespace; anything else opens a statement
                if (c == C_SPACE || c == C_TAB || c == C_LF || c == C_CR || c == C_FF) begin
                    act.copy = 1'b0;
                    nxt = ST_WHTE;
                end else begin
                    nxt = ST_BODY;
                end
            end
        endcase
        return nxt;
    endfunction

    // Advances the model by one byte and returns the result words it causes.
    function automatic void split_byte(input logic [7:0] c, input logic eos,
                                       output t_result res [3], output int n);
        t_action     act;
        t_scan_state nxt;
        logic [7:0]  chars [3];
        logic        fin;
        n = 0;
        nxt = next_scan(scan, c, act);
        if (act.hold && held_n < 2) begin
            held[held_n] = c;
            held_n++;
        end
        if (act.xfer) begin
            for (int i = 0; i < held_n; i++) begin
                chars[n] = held[i];
                n++;
            end
            held_n = 0;
        end
        if (act.drop)
            held_n = 0;
        if (act.copy) begin
            chars[n] = c;
            n++;
        end
        fin = (nxt == ST_TERM) || eos;
        if (fin) begin
            nxt = ST_WHTE;
            held_n = 0;
        end
        scan = nxt;
        if (n == 0) begin
            res[0] = '{1'b0, 8'h00, fin, 1'b1};
            n = 1;
        end else begin
            for (int k = 0; k < n; k++)
                res[k] = '{1'b1, chars[k], fin && (k == n - 1), k == n - 1};
        end
    endfunction

    // ---- bookkeeping ----
    t_result pending_words [$];
    int      errors = 0;
    int      bytes_sent = 0;
    int      words_seen = 0;
    int      stmt_ends = 0;
    bit      bursts_on = 1'b1;
    bit      long_hold_req = 1'b0;

    // Weighted byte picker: mostly scanner-significant characters so strings,
    // comments and held dashes get opened and closed often; some raw bytes and letters.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return (r < 3) ? C_SPACE : (r < 5) ? C_TAB : (r < 7) ? C_CR : C_FF;
        if (r < 20) return C_DASH;
        if (r < 27) return C_SEMI;
        if (r < 33) return C_SQUOTE;
        if (r < 39) return C_DQUOTE;
        if (r < 43) return C_BSLASH;
        if (r < 47) return C_SLASH;
        if (r < 51) return C_STAR;
        if (r < 55) return C_BTICK;
        if (r < 59) return C_HASH;
        if (r < 66) return C_LF;
        if (r < 80) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Offers one byte (after an optional idle burst) and, once taken, queues
    // the words it should produce: the typed word if given, else the model's.
    task automatic send_byte(input logic [7:0] c, input logic eos,
                             input logic typed, input t_result want);
        t_result res [3];
        int      n;
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= c;
        in_ch.end_of_script <= eos;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        split_byte(c, eos, res, n);
        if (typed) begin
            pending_words.push_back(want);
        end else begin
            for (int k = 0; k < n; k++)
                pending_words.push_back(res[k]);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // ---- output checker: compare each accepted word with the oldest expected ----
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.char_valid, out_ch.out_char, out_ch.stmt_end, out_ch.last};
            words_seen++;
            if (got.stmt_end)
                stmt_ends++;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word cv=%b char=%02h end=%b last=%b", $time,
                         got.char_valid, got.out_char, got.stmt_end, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got.char_valid !== want.char_valid || got.out_char !== want.out_char ||
                    got.stmt_end !== want.stmt_end || got.last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch, expected %b/%02h/%b/%b, got %b/%02h/%b/%b",
                             $time, want.char_valid, want.out_char, want.stmt_end,
                             want.last, got.char_valid, got.out_char, got.stmt_end,
                             got.last);
                end
            end
        end
    end

    // ---- receiver: random stall bursts, plus one long hold on request ----
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                // long enough for the result buffer and input register to fill
                long_hold_req = 1'b0;
                stall_left = 150;
            end else if (stall_left == 0 && bursts_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---- main sequence ----
    initial begin
        logic [7:0] c;
        logic       eos;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.end_of_script = 1'b0;
        scan = ST_WHTE;
        held_n = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_byte(DIR_TAB[i].in_byte, DIR_TAB[i].eos, DIR_TAB[i].typed,
                      DIR_TAB[i].want);

        for (int i = 0; i < N_RAND; i++) begin
            // a calm window mid-run, and no idling at all near the end
            bursts_on = !((i >= 150 && i < 210) || i >= 330);
            if (i == 50)
                long_hold_req = 1'b1;
            c = pick_byte();
            eos = (i == N_RAND - 1) || ($urandom_range(0, 39) == 0);
            send_byte(c, eos, 1'b0, NO_WANT);
        end
        in_ch.valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d script bytes (directed and weighted random, with stalls on both sides);",
                 bytes_sent);
        $display("checked %0d result words, %0d of them closing a statement.",
                 words_seen, stmt_ends);
        if (errors == 0) begin
            $display("sql_statement_splitter test passed");
        end else begin
            $display("sql_statement_splitter test failed");
        end
        $finish;
    end

    // ---- watchdog ----
    initial begin
        #4_000_000;
        $display("sql_statement_splitter test failed");
        $finish;
    end

endmodule
